// ===== rtl/epba_pkg.sv =====
// ----------------------------------------------------------------------------
// epba_pkg
// shared constants and types of the edge padded boxcar average core
// ----------------------------------------------------------------------------
package epba_pkg;

  // width and reset value of the window length register
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd8;

  // entries of the queue between the front and the back end
  localparam int QUEUE_DEPTH = 4;

  // classification of one accepted sample
  typedef struct packed {
    logic first;
    logic last;
  } item_flags_t;

  // control of one window sum handed to the divider
  typedef struct packed {
    logic valid;
    logic last;
  } step_ctl_t;

endpackage

// ===== rtl/epba_front.sv =====
// ----------------------------------------------------------------------------
// epba_front
// accepts samples, marks record starts, latches the window and queues items
// ----------------------------------------------------------------------------
module epba_front #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   push,
  input  logic signed [SAMPLE_BITS-1:0]          sample_value,
  input  logic                                   record_end,
  input  logic [epba_pkg::CFG_W-1:0]             window_length,
  output logic                                   full,
  input  logic                                   q_pop,
  output logic                                   q_valid,
  output logic signed [SAMPLE_BITS-1:0]          q_sample,
  output epba_pkg::item_flags_t                  q_flags,
  output logic [$clog2(MAX_WINDOW+1)-1:0]        q_len
);

  localparam int LW  = $clog2(MAX_WINDOW + 1);
  localparam int CW  = (LW > epba_pkg::CFG_W) ? LW : epba_pkg::CFG_W;
  localparam int QAW = $clog2(epba_pkg::QUEUE_DEPTH);
  localparam int QCW = $clog2(epba_pkg::QUEUE_DEPTH + 1);

  logic signed [SAMPLE_BITS-1:0] x_q   [epba_pkg::QUEUE_DEPTH];
  epba_pkg::item_flags_t         f_q   [epba_pkg::QUEUE_DEPTH];
  logic [LW-1:0]                 len_q [epba_pkg::QUEUE_DEPTH];

  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;
  logic           first_pending_r, first_pending_nxt;
  logic           push_ok;
  logic [CW-1:0]  wl_ext;
  logic [CW-1:0]  len_clamp;
  epba_pkg::item_flags_t flags_in;

  assign full    = (count_r == QCW'(epba_pkg::QUEUE_DEPTH));
  assign push_ok = push && !full;
  assign q_valid = (count_r != '0);

  // zero acts as one, anything past the store depth as the depth
  always_comb begin
    wl_ext = CW'(window_length);
    if (wl_ext == '0) begin
      len_clamp = CW'(1);
    end else if (wl_ext > CW'(MAX_WINDOW)) begin
      len_clamp = CW'(MAX_WINDOW);
    end else begin
      len_clamp = wl_ext;
    end
  end

  assign flags_in.first = first_pending_r;
  assign flags_in.last  = record_end;

  always_comb begin
    wr_ptr_nxt        = push_ok ? QAW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt        = q_pop ? QAW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    first_pending_nxt = push_ok ? record_end : first_pending_r;
    unique case ({push_ok, q_pop})
      2'b10:   count_nxt = QCW'(count_r + 1'b1);
      2'b01:   count_nxt = QCW'(count_r - 1'b1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r        <= '0;
      rd_ptr_r        <= '0;
      count_r         <= '0;
      first_pending_r <= 1'b1;
    end else begin
      wr_ptr_r        <= wr_ptr_nxt;
      rd_ptr_r        <= rd_ptr_nxt;
      count_r         <= count_nxt;
      first_pending_r <= first_pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      x_q[wr_ptr_r]   <= sample_value;
      f_q[wr_ptr_r]   <= flags_in;
      len_q[wr_ptr_r] <= LW'(len_clamp);
    end
  end

  assign q_sample = x_q[rd_ptr_r];
  assign q_flags  = f_q[rd_ptr_r];
  assign q_len    = len_q[rd_ptr_r];

endmodule

// ===== rtl/epba_window.sv =====
// ----------------------------------------------------------------------------
// epba_window
// back end sequencer, sample ring and running window sum
// ----------------------------------------------------------------------------
module epba_window #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  logic                                                adv,
  input  logic                                                q_valid,
  input  logic signed [SAMPLE_BITS-1:0]                       q_sample,
  input  epba_pkg::item_flags_t                               q_flags,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]                     q_len,
  output logic                                                q_pop,
  output epba_pkg::step_ctl_t                                 sum_ctl,
  output logic [$clog2(MAX_WINDOW+1)-1:0]                     sum_len,
  output logic signed [SAMPLE_BITS+$clog2(MAX_WINDOW+1)-1:0]  sum_value
);

  localparam int LW    = $clog2(MAX_WINDOW + 1);
  localparam int AW    = $clog2(MAX_WINDOW);
  localparam int CNTW  = $clog2(MAX_WINDOW + 2);
  localparam int SUM_W = SAMPLE_BITS + LW;

  logic signed [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];

  // sequencer and record state
  logic [LW-1:0]                 rep_r;
  logic [LW-1:0]                 len_r;
  logic signed [SAMPLE_BITS-1:0] first_r;
  logic [CNTW-1:0]               cnt_r;
  logic [AW-1:0]                 pos_r;

  // issue stage
  logic                          a_valid_r;
  logic signed [SAMPLE_BITS-1:0] a_x_r;
  logic signed [SAMPLE_BITS-1:0] a_firstval_r;
  logic [LW-1:0]                 a_len_r;
  logic                          a_first_r;
  logic                          a_leave_first_r;
  logic                          a_emit_r;
  logic                          a_last_r;
  logic signed [SAMPLE_BITS-1:0] rd_r;

  // sum stage
  epba_pkg::step_ctl_t           b_ctl_r;
  logic [LW-1:0]                 b_len_r;
  logic signed [SUM_W-1:0]       sum_r;

  logic                          fire, is_first, done, step_last;
  logic [LW-1:0]                 len_cur, dly;
  logic [CNTW-1:0]               cnt_new;
  logic                          leave_first, emit;
  logic signed [SAMPLE_BITS-1:0] first_cur, leave;
  logic [LW-1:0]                 pos_ext;
  logic [AW-1:0]                 rd_addr, pos_nxt;
  logic signed [SUM_W-1:0]       prod, sum_nxt;

  always_comb begin
    is_first  = q_flags.first && (rep_r == '0);
    len_cur   = is_first ? q_len : len_r;
    dly       = LW'(len_cur - 1'b1 - (len_cur >> 1));
    step_last = q_flags.last && (rep_r == dly);
    done      = !q_flags.last || step_last;
    fire      = adv && q_valid;
    q_pop     = fire && done;

    if (is_first) begin
      cnt_new = CNTW'(1);
    end else if (cnt_r == CNTW'(MAX_WINDOW + 1)) begin
      cnt_new = cnt_r;
    end else begin
      cnt_new = CNTW'(cnt_r + 1'b1);
    end
    // leaving sample lies before the record start
    leave_first = (cnt_new <= CNTW'(len_cur));
    emit        = (cnt_new > CNTW'(dly));
    first_cur   = is_first ? q_sample : first_r;

    pos_ext = LW'(pos_r);
    if (pos_ext >= len_cur) begin
      rd_addr = AW'(pos_ext - len_cur);
    end else begin
      rd_addr = AW'(pos_ext + LW'(MAX_WINDOW) - len_cur);
    end
    pos_nxt = (pos_r == AW'(MAX_WINDOW - 1)) ? '0 : AW'(pos_r + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_r     <= '0;
      pos_r     <= '0;
      a_valid_r <= 1'b0;
      b_ctl_r   <= '0;
    end else if (adv) begin
      a_valid_r     <= q_valid;
      b_ctl_r.valid <= a_valid_r && a_emit_r;
      b_ctl_r.last  <= a_last_r;
      if (fire) begin
        rep_r <= done ? '0 : LW'(rep_r + 1'b1);
        pos_r <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      len_r           <= len_cur;
      first_r         <= first_cur;
      cnt_r           <= cnt_new;
      a_x_r           <= q_sample;
      a_firstval_r    <= first_cur;
      a_len_r         <= len_cur;
      a_first_r       <= is_first;
      a_leave_first_r <= leave_first;
      a_emit_r        <= emit;
      a_last_r        <= step_last;
      rd_r            <= ring_mem[rd_addr];
      ring_mem[pos_r] <= q_sample;
    end
  end

  always_comb begin
    leave   = a_leave_first_r ? a_firstval_r : rd_r;
    prod    = SUM_W'(a_x_r) * SUM_W'($signed({1'b0, a_len_r}));
    sum_nxt = a_first_r ? prod : SUM_W'(sum_r + SUM_W'(a_x_r) - SUM_W'(leave));
  end

  always_ff @(posedge clk) begin
    if (adv && a_valid_r) begin
      sum_r   <= sum_nxt;
      b_len_r <= a_len_r;
    end
  end

  assign sum_ctl   = b_ctl_r;
  assign sum_len   = b_len_r;
  assign sum_value = sum_r;

endmodule

// ===== rtl/epba_divider.sv =====
// ----------------------------------------------------------------------------
// epba_divider
// pipelined floor division of the scaled sum by the window, one bit a stage
// ----------------------------------------------------------------------------
module epba_divider #(
  parameter int MAX_WINDOW    = 64,
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 6
) (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  epba_pkg::step_ctl_t                                 sum_ctl,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]                     sum_len,
  input  logic signed [SAMPLE_BITS+$clog2(MAX_WINDOW+1)-1:0]  sum_value,
  input  logic                                                out_pop,
  output logic                                                adv,
  output logic                                                out_empty,
  output logic signed [SAMPLE_BITS+FRACTION_BITS-1:0]         out_average_value,
  output logic                                                out_output_last
);

  localparam int LW    = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_BITS + LW;
  localparam int NUM_W = SUM_W + FRACTION_BITS;
  localparam int UW    = NUM_W - 1;
  localparam int QW    = SAMPLE_BITS + FRACTION_BITS - 1;

  logic [LW-1:0] rem_r   [QW+1];
  logic [QW-1:0] quo_r   [QW+1];
  logic [LW-1:0] len_r   [QW+1];
  logic          neg_r   [QW+1];
  logic          last_r  [QW+1];
  logic          valid_r [QW+1];

  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        mag;
  logic                    neg;

  // floor(n/L) for negative n is ~((~n)/L)
  always_comb begin
    num = NUM_W'(sum_value) <<< FRACTION_BITS;
    neg = sum_value[SUM_W-1];
    mag = neg ? ~num : num;
  end

  assign adv = !valid_r[QW] || out_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QW; k++) begin
        valid_r[k] <= 1'b0;
      end
    end else if (adv) begin
      valid_r[0] <= sum_ctl.valid;
      for (int k = 0; k < QW; k++) begin
        valid_r[k+1] <= valid_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= mag[UW-1:QW];
      quo_r[0]  <= mag[QW-1:0];
      len_r[0]  <= sum_len;
      neg_r[0]  <= neg;
      last_r[0] <= sum_ctl.last;
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic [LW:0] trial;
    logic        ge;

    always_comb begin
      trial = {rem_r[g], quo_r[g][QW-1]};
      ge    = (trial >= {1'b0, len_r[g]});
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[g+1]  <= ge ? LW'(trial - {1'b0, len_r[g]}) : LW'(trial);
        quo_r[g+1]  <= {quo_r[g][QW-2:0], ge};
        len_r[g+1]  <= len_r[g];
        neg_r[g+1]  <= neg_r[g];
        last_r[g+1] <= last_r[g];
      end
    end
  end

  assign out_empty         = !valid_r[QW];
  assign out_average_value = neg_r[QW] ? ~{1'b0, quo_r[QW]} : {1'b0, quo_r[QW]};
  assign out_output_last   = last_r[QW];

endmodule

// ===== rtl/edge_padded_boxcar_average_core.sv =====
// ----------------------------------------------------------------------------
// edge_padded_boxcar_average_core: centered boxcar average, edge replicated
// result path: front queue, issue stage, sum stage, divider stages, result register
// throughput one window step a cycle when not stalled; a record-end sample takes D+1 steps,
// D = L-1-floor(L/2), set by the back-end sequencer; divider is fully piped
// synchronous active-low reset clears control only; sample ring undefined
// ----------------------------------------------------------------------------
module edge_padded_boxcar_average_core #(
  parameter int MAX_WINDOW    = 64,
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 6
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  // sample channel
  input  logic                                        in_push,
  output logic                                        in_full,
  input  logic signed [SAMPLE_BITS-1:0]               in_sample_value,
  input  logic                                        in_record_end,
  // result channel
  output logic                                        out_empty,
  input  logic                                        out_pop,
  output logic signed [SAMPLE_BITS+FRACTION_BITS-1:0] out_average_value,
  output logic                                        out_output_last,
  // window length register
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic [epba_pkg::CFG_W-1:0]                  cfg_window_length
);

  localparam int LW    = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_BITS + LW;

  // window length register, always ready for a transfer
  logic [epba_pkg::CFG_W-1:0] window_length_r;

  // front to back queue head
  logic                          q_valid;
  logic                          q_pop;
  logic signed [SAMPLE_BITS-1:0] q_sample;
  epba_pkg::item_flags_t         q_flags;
  logic [LW-1:0]                 q_len;

  // window sum to divider
  epba_pkg::step_ctl_t           sum_ctl;
  logic [LW-1:0]                 sum_len;
  logic signed [SUM_W-1:0]       sum_value;

  // whole back end moves together while the result register can take data
  logic                          adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= epba_pkg::WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      window_length_r <= cfg_window_length;
    end
  end

  // front: tags the first sample of each record, clamps the window
  // length and parks items in a short queue; input waits only once it is full
  epba_front #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (in_push),
    .sample_value  (in_sample_value),
    .record_end    (in_record_end),
    .window_length (window_length_r),
    .full          (in_full),
    .q_pop         (q_pop),
    .q_valid       (q_valid),
    .q_sample      (q_sample),
    .q_flags       (q_flags),
    .q_len         (q_len)
  );

  // back end, part one: one window step a cycle while the back end advances; a record
  // end is replayed as copies of the last sample until every pending average is out.
  // the sum slides by adding the newest sample and dropping the one L back,
  // with the first sample standing in for indices before the record
  epba_window #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .q_valid   (q_valid),
    .q_sample  (q_sample),
    .q_flags   (q_flags),
    .q_len     (q_len),
    .q_pop     (q_pop),
    .sum_ctl   (sum_ctl),
    .sum_len   (sum_len),
    .sum_value (sum_value)
  );

  // back end, part two: floor(sum * 2^FRACTION_BITS / L), one quotient bit
  // per stage; its last stage is the result register
  epba_divider #(
    .MAX_WINDOW    (MAX_WINDOW),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_divider (
    .clk               (clk),
    .rst_n             (rst_n),
    .sum_ctl           (sum_ctl),
    .sum_len           (sum_len),
    .sum_value         (sum_value),
    .out_pop           (out_pop),
    .adv               (adv),
    .out_empty         (out_empty),
    .out_average_value (out_average_value),
    .out_output_last   (out_output_last)
  );

endmodule

// ===== rtl/epba_checker.sv =====
// ----------------------------------------------------------------------------
// epba_checker
// port level checks of the boxcar average core, bound to the top level
// ----------------------------------------------------------------------------
module epba_checker #(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 6
) (
  input logic                                        clk,
  input logic                                        rst_n,
  input logic                                        in_push,
  input logic                                        in_full,
  input logic                                        out_empty,
  input logic                                        out_pop,
  input logic signed [SAMPLE_BITS+FRACTION_BITS-1:0] out_average_value,
  input logic                                        out_output_last
);

  // reset drains the result side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending after reset");

  // reset empties the queue
  a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

  // queue only fills through an input transfer
  a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push && !in_full))
    else $error("input went full without a transfer");

  // a waiting result holds until taken
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_average_value) && $stable(out_output_last)))
    else $error("waiting result changed");

endmodule

bind edge_padded_boxcar_average_core epba_checker #(
  .SAMPLE_BITS   (SAMPLE_BITS),
  .FRACTION_BITS (FRACTION_BITS)
) u_epba_checker (.*);

// ===== tb/edge_padded_boxcar_average_core_tb.sv =====
// ----------------------------------------------------------------------------
// edge_padded_boxcar_average_core_tb
// self-checking bench for the centered boxcar average with edge replication:
// a directed table, then random records of random length under changing
// window settings.
// every accepted sample runs through a local predictor, and each popped
// average is compared field by field with the oldest expected one
// ----------------------------------------------------------------------------
module edge_padded_boxcar_average_core_tb;

  localparam int MAX_WINDOW    = 64;
  localparam int SAMPLE_BITS   = 16;
  localparam int FRACTION_BITS = 6;
  localparam int AVG_BITS      = SAMPLE_BITS + FRACTION_BITS;
  localparam int COUNT_MAX     = 65535;

  // drain time after the last expected average, well past the divider depth
  localparam int SETTLE_CYCLES = 60;
  localparam int LIMIT_CYCLES  = 3000000;
  localparam int RANDOM_ITEMS  = 300;
  localparam int DIRECTED_ROWS = 22;

  typedef logic signed [SAMPLE_BITS-1:0]  sample_t;
  typedef logic signed [AVG_BITS-1:0]     average_t;
  typedef logic [epba_pkg::CFG_W-1:0]     window_t;

  typedef struct packed {
    average_t value;
    logic     last;
  } average_result_t;

  // one row of the directed table; a window write happens before the sample
  typedef struct packed {
    logic     set_win;
    window_t  win;
    sample_t  sample;
    logic     rec_end;
    logic     typed;
    average_t avg;
    logic     last;
  } stim_row_t;

  typedef enum int {POP_ALWAYS, POP_COIN, POP_STALLS, POP_MOSTLY} pop_style_t;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_push = 1'b0;
  logic     in_full;
  sample_t  in_sample_value = '0;
  logic     in_record_end = 1'b0;
  logic     out_empty;
  logic     out_pop = 1'b0;
  average_t out_average_value;
  logic     out_output_last;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  window_t  cfg_window_length = '0;

  edge_padded_boxcar_average_core #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_sample_value  (in_sample_value),
    .in_record_end    (in_record_end),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_average_value(out_average_value),
    .out_output_last  (out_output_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_window_length(cfg_window_length)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // predictor state, mirrors the block from reset on
  window_t         window_reg = epba_pkg::WINDOW_RESET;
  sample_t         ring [MAX_WINDOW];
  sample_t         rec_first = '0;
  int              rec_count = 0;
  int              span = 8;
  int              ring_wr = 0;
  average_result_t step_results[$];
  average_result_t pending_averages[$];

  int mismatch_count = 0;
  int cycle_count = 0;

  // sender pacing
  int burst_left = 0;
  bit sender_steady = 1'b0;

  // receiver pacing
  pop_style_t      pop_style = POP_ALWAYS;
  int              style_left = 0;
  int              stall_left = 0;
  average_result_t head;

  // directed table: window 1 rows carry their averages typed in (sample times 64)
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // reset window 8: short record, everything flushed by its last sample
    '{1'b0, 7'd0,   16'sd100,   1'b0, 1'b0, 22'sd0,       1'b0},
    '{1'b0, 7'd0,   -16'sd200,  1'b0, 1'b0, 22'sd0,       1'b0},
    '{1'b0, 7'd0,   16'sd300,   1'b1, 1'b0, 22'sd0,       1'b0},
    // window zero acts as one: average is the sample itself
    '{1'b1, 7'd0,   16'sh7fff,  1'b0, 1'b1, 22'sd2097088, 1'b0},
    '{1'b0, 7'd0,   16'sh8000,  1'b0, 1'b1, 22'sh200000,  1'b0},
    '{1'b0, 7'd0,   16'sd0,     1'b1, 1'b1, 22'sd0,       1'b1},
    '{1'b0, 7'd0,   -16'sd1,    1'b1, 1'b1, -22'sd64,     1'b1},
    // too wide clamps to 64: the last of two samples flushes both averages
    '{1'b1, 7'd127, 16'sh7fff,  1'b0, 1'b0, 22'sd0,       1'b0},
    '{1'b0, 7'd0,   16'sh7fff,  1'b1, 1'b0, 22'sd0,       1'b0},
    // single-sample record at the full window
    '{1'b1, 7'd64,  16'sh8000,  1'b1, 1'b0, 22'sd0,       1'b0},
    '{1'b1, 7'd65,  16'sd5,     1'b0, 1'b0, 22'sd0,       1'b0},
    '{1'b0, 7'd0,   -16'sd7,    1'b0, 1'b0, 22'sd0,       1'b0},
    '{1'b0, 7'd0,   16'sd9,     1'b1, 1'b0, 22'sd0,       1'b0},
    // even window with no delay
    '{1'b1, 7'd2,   16'sd1,     1'b0, 1'b0, 22'sd0,       1'b0},
    '{1'b0, 7'd0,   16'sd2,     1'b0, 1'b0, 22'sd0,       1'b0},
    '{1'b0, 7'd0,   16'sd3,     1'b1, 1'b0, 22'sd0,       1'b0},
    // window change mid-record only applies to the next record
    '{1'b1, 7'd3,   16'sd10,    1'b0, 1'b0, 22'sd0,       1'b0},
    '{1'b0, 7'd0,   16'sd20,    1'b0, 1'b0, 22'sd0,       1'b0},
    '{1'b1, 7'd2,   16'sd30,    1'b0, 1'b0, 22'sd0,       1'b0},
    '{1'b0, 7'd0,   16'sd40,    1'b1, 1'b0, 22'sd0,       1'b0},
    '{1'b0, 7'd0,   16'sd50,    1'b0, 1'b0, 22'sd0,       1'b0},
    '{1'b0, 7'd0,   16'sd60,    1'b1, 1'b0, 22'sd0,       1'b0}
  };

  function automatic int clamp_span(window_t w);
    if (w == 0) return 1;
    if (w > MAX_WINDOW) return MAX_WINDOW;
    return int'(w);
  endfunction

  // sample r places before the newest; past the end replicates the newest,
  // before the record start replicates the first sample
  function automatic sample_t sample_back(int r);
    int rr;
    rr = (r < 0) ? 0 : r;
    if (rr >= rec_count) return rec_first;
    return ring[(ring_wr + MAX_WINDOW - 1 - rr) % MAX_WINDOW];
  endfunction

  // averages caused by one accepted sample, left in step_results
  function automatic void predict_averages(sample_t x, logic rec_end);
    int              half;
    int              lag;
    int              top;
    longint          acc;
    longint          num;
    longint          q;
    average_result_t res;
    step_results.delete();
    if (rec_count == 0) begin
      span = clamp_span(window_reg);
      rec_first = x;
    end
    ring[ring_wr] = x;
    ring_wr = (ring_wr + 1) % MAX_WINDOW;
    if (rec_count < COUNT_MAX) rec_count++;
    half = span / 2;
    lag = span - 1 - half;
    top = rec_end ? lag : 0;
    for (int m = 0; m <= top; m++) begin
      if (m + rec_count > lag) begin
        acc = 0;
        for (int r = -m; r <= span - 1 - m; r++) acc += sample_back(r);
        num = acc * (longint'(1) << FRACTION_BITS);
        // floor division
        q = num / span;
        if ((num % span) != 0 && num < 0) q--;
        res.value = q[AVG_BITS-1:0];
        res.last = rec_end && (m == lag);
        step_results.push_back(res);
      end
    end
    if (rec_end) begin
      rec_count = 0;
      ring_wr = 0;
    end
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return sample_t'(int'($urandom_range(0, 16)) - 8);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic window_t random_window();
    case ($urandom_range(0, 9))
      0: return window_t'(0);
      1: return window_t'(MAX_WINDOW);
      2: return window_t'(127);
      3: return window_t'($urandom_range(65, 126));
      4, 5: return window_t'($urandom_range(17, 63));
      default: return window_t'($urandom_range(1, 16));
    endcase
  endfunction

  // mostly mid-length records, some short ones and some that wrap the ring
  function automatic int random_record_len();
    case ($urandom_range(0, 7))
      0: return 1;
      1: return $urandom_range(2, 6);
      2: return $urandom_range(65, 110);
      default: return $urandom_range(5, 40);
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // bursts of random length, random gaps between them
  task automatic next_slot();
    int gap;
    if (burst_left == 0) begin
      gap = sender_steady ? 0 : $urandom_range(0, 6);
      if (!sender_steady && $urandom_range(0, 9) == 0) gap = $urandom_range(10, 30);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  // one sample transfer; expectations come from the table or the predictor
  task automatic push_sample(sample_t x, logic rec_end, logic typed, average_t typed_avg,
                             logic typed_last);
    average_result_t res;
    next_slot();
    in_push <= 1'b1;
    in_sample_value <= x;
    in_record_end <= rec_end;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_averages(x, rec_end);
    if (typed) begin
      res.value = typed_avg;
      res.last = typed_last;
      pending_averages.push_back(res);
    end else begin
      foreach (step_results[i]) pending_averages.push_back(step_results[i]);
    end
  endtask

  // idle: every expected average out, then the pipe given time to empty
  task automatic settle();
    in_push <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(window_t w);
    settle();
    cfg_valid <= 1'b1;
    cfg_window_length <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    window_reg = w;
    cfg_valid <= 1'b0;
  endtask

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: check each transfer, then pick the next pop
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_averages.size() == 0) begin
        report_mismatch("average with none pending", out_average_value, 0);
      end else begin
        head = pending_averages.pop_front();
        if (out_average_value !== head.value)
          report_mismatch("average_value", out_average_value, head.value);
        if (out_output_last !== head.last)
          report_mismatch("output_last", out_output_last, head.last);
      end
    end
    // stall pattern changes style every so often, always-pop stretches included
    if (style_left == 0) begin
      pop_style = pop_style_t'($urandom_range(0, 3));
      style_left = $urandom_range(20, 200);
    end
    style_left--;
    case (pop_style)
      POP_ALWAYS: out_pop <= 1'b1;
      POP_COIN: out_pop <= ($urandom_range(0, 1) == 1);
      POP_STALLS: begin
        if (stall_left > 0) begin
          stall_left--;
          out_pop <= 1'b0;
        end else begin
          out_pop <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 24);
        end
      end
      default: out_pop <= ($urandom_range(0, 3) != 0);
    endcase
  end

  initial begin
    int sent;
    int rec_left;
    int phase_len;
    stim_row_t row;
    sent = 0;
    rec_left = 0;

    // reset held at the start, then released
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_rows[i];
      if (row.set_win) write_window(row.win);
      push_sample(row.sample, row.rec_end, row.typed, row.avg, row.last);
    end

    // random records; phases may end mid-record so window writes land there too
    while (sent < RANDOM_ITEMS || rec_left != 0) begin
      if ($urandom_range(0, 2) == 0) write_window(random_window());
      sender_steady = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(8, 60);
      for (int k = 0; k < phase_len && (sent < RANDOM_ITEMS || rec_left != 0); k++) begin
        if (rec_left == 0) rec_left = random_record_len();
        push_sample(random_sample(), rec_left == 1, 1'b0, '0, 1'b0);
        rec_left--;
        sent++;
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/epba_pkg.sv
rtl/epba_front.sv
rtl/epba_window.sv
rtl/epba_divider.sv
rtl/edge_padded_boxcar_average_core.sv
rtl/epba_checker.sv
tb/edge_padded_boxcar_average_core_tb.sv
